// ===== hw/rtl/matrix_multiply_accumulate_top_assert.svh =====
// Assertion macros for the RTL, used by mma_ctrl. Each expands to nothing in synthesis.
`ifndef MATRIX_MULTIPLY_ACCUMULATE_TOP_ASSERT_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define MMA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MMA_ASSERT_IMP(label, clk, rst, ante, cons)
`define MMA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/mma_pkg.sv =====
`timescale 1ns / 1ps
package mma_pkg;

  localparam int MAX_DIM   = 16;
  localparam int FRAC_BITS = 16;

  localparam int DIM_LIMIT = (MAX_DIM < 16) ? MAX_DIM : 16;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = 5;
  localparam int DATA_W    = 32;
  localparam int MUL_X_W   = DATA_W + 1;
  localparam int PROD_W    = MUL_X_W + DATA_W;
  localparam int ACC_W     = 2 * DATA_W + $clog2(MAX_DIM);
  localparam int SUM_W     = ACC_W + 34;

  // Half an output LSB at the product scale, for round to nearest
  localparam logic [SUM_W:0] ROUND_TWICE = (SUM_W + 1)'(1) << (2 * FRAC_BITS);
  localparam logic signed [SUM_W-1:0] ROUND_K = SUM_W'(ROUND_TWICE >> 1);

  localparam logic [2:0] REG_ALPHA   = 3'd0;
  localparam logic [2:0] REG_BETA    = 3'd1;
  localparam logic [2:0] REG_ROWS_M  = 3'd2;
  localparam logic [2:0] REG_INNER_K = 3'd3;
  localparam logic [2:0] REG_COLS_N  = 3'd4;

  localparam logic [CNT_W-1:0] RESET_DIM   = CNT_W'(16);
  localparam logic [DATA_W-1:0] RESET_ALPHA = DATA_W'(65536);

  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_LOAD_C  = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_AB,
    OP_ALPHA_LO,
    OP_ALPHA_MID,
    OP_ALPHA_HI,
    OP_BETA
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COL,
    ST_MAC,
    ST_MAC_WAIT,
    ST_SCALE,
    ST_SCALE_WAIT,
    ST_ROUND
  } state_t;

  typedef struct packed {
    op_t  op;
    logic clr;
    logic cold_load;
  } ctl_t;

  typedef struct packed {
    logic              idle;
    logic [DATA_W-1:0] value;
    logic              sat;
  } dp_stat_t;

  typedef struct packed {
    logic              a_we;
    logic              b_we;
    logic              c_we;
    logic              c_wr_result;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] a_raddr;
    logic [ADDR_W-1:0] b_raddr;
    logic [ADDR_W-1:0] c_raddr;
  } mem_ctl_t;

  function automatic logic [CNT_W-1:0] dim_use(logic [CNT_W-1:0] v);
    return (v > CNT_W'(DIM_LIMIT)) ? CNT_W'(DIM_LIMIT) : v;
  endfunction

  function automatic logic [ADDR_W-1:0] elem_addr(logic [CNT_W-1:0] r,
                                                  logic [CNT_W-1:0] c);
    logic [ADDR_W+CNT_W:0] full;
    full = (ADDR_W + CNT_W + 1)'(r) * (ADDR_W + CNT_W + 1)'(MAX_DIM)
         + (ADDR_W + CNT_W + 1)'(c);
    return full[ADDR_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/matrix_multiply_accumulate_top.sv =====
`timescale 1ns / 1ps
// C = alpha*A*B + beta*C in signed Q16.16. Load requests (tuser 0, 1, 2) write one
// element of A, B or C; out-of-range loads are dropped. A compute request (tuser 3)
// names a row of C and yields one result per column in use, tlast on the final
// column; each result is written back to C. For each column, one shared 33x32
// multiplier fed by registered RAM reads runs a setup step, one multiply-accumulate
// per inner index in use, a drain, four scaling products, another drain and a
// rounding step. The input side is ready only between requests. A finished result
// waits in the output register; while it is held, the next result of the row stalls
// in rounding.
module matrix_multiply_accumulate_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // row_index[3:0], col_index[7:4], element_value[39:8]
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_row[3:0], out_col[7:4], out_value[39:8]
  output logic [0:0]  m_tuser,   // saturated[0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic signed [mma_pkg::DATA_W-1:0] alpha;
  logic signed [mma_pkg::DATA_W-1:0] beta;
  logic [mma_pkg::CNT_W-1:0]         rows_m;
  logic [mma_pkg::CNT_W-1:0]         inner_k;
  logic [mma_pkg::CNT_W-1:0]         cols_n;

  logic [2:0] reg_idx;
  logic       cfg_wr;

  mma_pkg::ctl_t     ctl;
  mma_pkg::mem_ctl_t mem;
  mma_pkg::dp_stat_t stat;

  logic [mma_pkg::DATA_W-1:0] a_rdata;
  logic [mma_pkg::DATA_W-1:0] b_rdata;
  logic [mma_pkg::DATA_W-1:0] c_rdata;
  logic [mma_pkg::DATA_W-1:0] c_wdata;

  logic [3:0]                 out_row;
  logic [3:0]                 out_col;
  logic [mma_pkg::DATA_W-1:0] out_value;
  logic                       out_sat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha   <= mma_pkg::RESET_ALPHA;
      beta    <= '0;
      rows_m  <= mma_pkg::RESET_DIM;
      inner_k <= mma_pkg::RESET_DIM;
      cols_n  <= mma_pkg::RESET_DIM;
    end else if (cfg_wr) begin
      case (reg_idx)
        mma_pkg::REG_ALPHA:   alpha   <= pwdata;
        mma_pkg::REG_BETA:    beta    <= pwdata;
        mma_pkg::REG_ROWS_M:  rows_m  <= pwdata[mma_pkg::CNT_W-1:0];
        mma_pkg::REG_INNER_K: inner_k <= pwdata[mma_pkg::CNT_W-1:0];
        mma_pkg::REG_COLS_N:  cols_n  <= pwdata[mma_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mma_pkg::REG_ALPHA:   prdata = alpha;
      mma_pkg::REG_BETA:    prdata = beta;
      mma_pkg::REG_ROWS_M:  prdata = 32'(rows_m);
      mma_pkg::REG_INNER_K: prdata = 32'(inner_k);
      mma_pkg::REG_COLS_N:  prdata = 32'(cols_n);
      default:              prdata = '0;
    endcase
  end

  mma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cmd       (mma_pkg::cmd_t'(s_tuser)),
    .row_index (s_tdata[3:0]),
    .col_index (s_tdata[7:4]),
    .rows_m    (rows_m),
    .inner_k   (inner_k),
    .cols_n    (cols_n),
    .stat      (stat),
    .ctl       (ctl),
    .mem       (mem),
    .m_tready  (m_tready),
    .out_valid (m_tvalid),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_sat   (out_sat),
    .out_last  (m_tlast)
  );

  mma_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .alpha   (alpha),
    .beta    (beta),
    .a_rdata (a_rdata),
    .b_rdata (b_rdata),
    .c_rdata (c_rdata),
    .stat    (stat)
  );

  assign c_wdata = mem.c_wr_result ? stat.value : s_tdata[39:8];

  mma_ram #(.WIDTH(mma_pkg::DATA_W), .DEPTH(mma_pkg::DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (mem.a_we),
    .waddr (mem.wr_addr),
    .wdata (s_tdata[39:8]),
    .raddr (mem.a_raddr),
    .rdata (a_rdata)
  );

  mma_ram #(.WIDTH(mma_pkg::DATA_W), .DEPTH(mma_pkg::DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (mem.b_we),
    .waddr (mem.wr_addr),
    .wdata (s_tdata[39:8]),
    .raddr (mem.b_raddr),
    .rdata (b_rdata)
  );

  mma_ram #(.WIDTH(mma_pkg::DATA_W), .DEPTH(mma_pkg::DEPTH)) u_c_ram (
    .clk   (clk),
    .we    (mem.c_we),
    .waddr (mem.wr_addr),
    .wdata (c_wdata),
    .raddr (mem.c_raddr),
    .rdata (c_rdata)
  );

  assign m_tdata = {out_value, out_col, out_row};
  assign m_tuser = out_sat;

endmodule

// ===== hw/rtl/mma_ram.sv =====
`timescale 1ns / 1ps
module mma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mma_dp.sv =====
`timescale 1ns / 1ps
module mma_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  mma_pkg::ctl_t                       ctl,
  input  logic signed [mma_pkg::DATA_W-1:0]   alpha,
  input  logic signed [mma_pkg::DATA_W-1:0]   beta,
  input  logic [mma_pkg::DATA_W-1:0]          a_rdata,
  input  logic [mma_pkg::DATA_W-1:0]          b_rdata,
  input  logic [mma_pkg::DATA_W-1:0]          c_rdata,
  output mma_pkg::dp_stat_t                   stat
);

  mma_pkg::op_t op_d;
  mma_pkg::op_t prod_op;
  logic         cold_d;

  logic signed [mma_pkg::MUL_X_W-1:0] mx;
  logic signed [mma_pkg::DATA_W-1:0]  my;
  logic signed [mma_pkg::PROD_W-1:0]  mul_full;
  logic signed [mma_pkg::PROD_W-1:0]  prod;
  logic signed [mma_pkg::DATA_W-1:0]  cold;
  logic signed [mma_pkg::ACC_W-1:0]   acc;
  logic signed [mma_pkg::SUM_W-1:0]   sum;
  logic signed [mma_pkg::SUM_W-1:0]   prod_ext;
  logic signed [mma_pkg::SUM_W-1:0]   term;
  logic signed [mma_pkg::SUM_W-1:0]   rsum;
  logic signed [mma_pkg::SUM_W-1:0]   shifted;
  logic                               neg;
  logic                               sat;

  // Operand select for the shared multiplier; ops arrive in the cycle after issue
  always_comb begin
    mx = '0;
    my = '0;
    case (op_d)
      mma_pkg::OP_AB: begin
        mx = mma_pkg::MUL_X_W'($signed(a_rdata));
        my = $signed(b_rdata);
      end
      mma_pkg::OP_ALPHA_LO: begin
        mx = $signed({1'b0, acc[31:0]});
        my = alpha;
      end
      mma_pkg::OP_ALPHA_MID: begin
        mx = $signed({1'b0, acc[63:32]});
        my = alpha;
      end
      mma_pkg::OP_ALPHA_HI: begin
        mx = mma_pkg::MUL_X_W'($signed(acc[mma_pkg::ACC_W-1:64]));
        my = alpha;
      end
      mma_pkg::OP_BETA: begin
        mx = mma_pkg::MUL_X_W'(cold);
        my = beta;
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
  end

  assign mul_full = mx * my;
  assign prod_ext = mma_pkg::SUM_W'(prod);

  // Place each partial product at its weight in the wide sum
  always_comb begin
    case (prod_op)
      mma_pkg::OP_ALPHA_LO:  term = prod_ext;
      mma_pkg::OP_ALPHA_MID: term = prod_ext <<< 32;
      mma_pkg::OP_ALPHA_HI:  term = prod_ext <<< 64;
      mma_pkg::OP_BETA:      term = prod_ext <<< mma_pkg::FRAC_BITS;
      default:               term = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_d    <= mma_pkg::OP_NONE;
      prod_op <= mma_pkg::OP_NONE;
      cold_d  <= 1'b0;
    end else begin
      op_d    <= ctl.op;
      prod_op <= op_d;
      cold_d  <= ctl.cold_load;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_full;
    if (cold_d) begin
      cold <= $signed(c_rdata);
    end
    if (ctl.clr) begin
      acc <= '0;
      sum <= '0;
    end else if (prod_op == mma_pkg::OP_AB) begin
      acc <= acc + mma_pkg::ACC_W'(prod);
    end else if (prod_op != mma_pkg::OP_NONE) begin
      sum <= sum + term;
    end
  end

  // Round to nearest, ties up, then clip to 32 bits
  assign rsum    = sum + mma_pkg::ROUND_K;
  assign shifted = rsum >>> (2 * mma_pkg::FRAC_BITS);
  assign neg     = shifted[mma_pkg::SUM_W-1];
  assign sat     = !((&shifted[mma_pkg::SUM_W-1:31]) || !(|shifted[mma_pkg::SUM_W-1:31]));

  always_comb begin
    stat.idle = (op_d == mma_pkg::OP_NONE) && (prod_op == mma_pkg::OP_NONE);
    stat.sat  = sat;
    if (sat) begin
      stat.value = neg ? {1'b1, {(mma_pkg::DATA_W-1){1'b0}}}
                       : {1'b0, {(mma_pkg::DATA_W-1){1'b1}}};
    end else begin
      stat.value = shifted[mma_pkg::DATA_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/mma_ctrl.sv =====
`timescale 1ns / 1ps
`include "matrix_multiply_accumulate_top_assert.svh"
module mma_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  mma_pkg::cmd_t                     cmd,
  input  logic [3:0]                        row_index,
  input  logic [3:0]                        col_index,
  input  logic [mma_pkg::CNT_W-1:0]         rows_m,
  input  logic [mma_pkg::CNT_W-1:0]         inner_k,
  input  logic [mma_pkg::CNT_W-1:0]         cols_n,
  input  mma_pkg::dp_stat_t                 stat,
  output mma_pkg::ctl_t                     ctl,
  output mma_pkg::mem_ctl_t                 mem,
  input  logic                              m_tready,
  output logic                              out_valid,
  output logic [3:0]                        out_row,
  output logic [3:0]                        out_col,
  output logic [mma_pkg::DATA_W-1:0]        out_value,
  output logic                              out_sat,
  output logic                              out_last
);

  mma_pkg::state_t state;
  mma_pkg::state_t state_next;

  logic [mma_pkg::CNT_W-1:0] t;
  logic [mma_pkg::CNT_W-1:0] j;
  logic [1:0]                s;
  logic [3:0]                row;

  logic [mma_pkg::CNT_W-1:0] m_use;
  logic [mma_pkg::CNT_W-1:0] k_use;
  logic [mma_pkg::CNT_W-1:0] n_use;
  logic [mma_pkg::CNT_W-1:0] in_row;
  logic [mma_pkg::CNT_W-1:0] in_col;
  logic                      accept;
  logic                      start;
  logic                      round_take;
  logic                      last_col;

  assign m_use  = mma_pkg::dim_use(rows_m);
  assign k_use  = mma_pkg::dim_use(inner_k);
  assign n_use  = mma_pkg::dim_use(cols_n);
  assign in_row = mma_pkg::CNT_W'(row_index);
  assign in_col = mma_pkg::CNT_W'(col_index);

  assign accept     = s_tvalid && s_tready;
  assign start      = accept && (cmd == mma_pkg::CMD_COMPUTE) && (in_row < m_use)
                      && (n_use != '0);
  assign round_take = !out_valid || m_tready;
  assign last_col   = (j + mma_pkg::CNT_W'(1)) == n_use;

  always_comb begin
    state_next = state;
    case (state)
      mma_pkg::ST_IDLE: begin
        if (start) state_next = mma_pkg::ST_COL;
      end
      mma_pkg::ST_COL: begin
        state_next = mma_pkg::ST_MAC;
      end
      mma_pkg::ST_MAC: begin
        if ((t + mma_pkg::CNT_W'(1)) >= k_use) state_next = mma_pkg::ST_MAC_WAIT;
      end
      mma_pkg::ST_MAC_WAIT: begin
        if (stat.idle) state_next = mma_pkg::ST_SCALE;
      end
      mma_pkg::ST_SCALE: begin
        if (s == 2'd3) state_next = mma_pkg::ST_SCALE_WAIT;
      end
      mma_pkg::ST_SCALE_WAIT: begin
        if (stat.idle) state_next = mma_pkg::ST_ROUND;
      end
      mma_pkg::ST_ROUND: begin
        if (round_take) state_next = last_col ? mma_pkg::ST_IDLE : mma_pkg::ST_COL;
      end
      default: begin
        state_next = mma_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready      = (state == mma_pkg::ST_IDLE);
    ctl.op        = mma_pkg::OP_NONE;
    ctl.clr       = 1'b0;
    ctl.cold_load = 1'b0;
    mem.a_we        = 1'b0;
    mem.b_we        = 1'b0;
    mem.c_we        = 1'b0;
    mem.c_wr_result = 1'b0;
    mem.wr_addr     = mma_pkg::elem_addr(in_row, in_col);
    mem.a_raddr     = mma_pkg::elem_addr(mma_pkg::CNT_W'(row), t);
    mem.b_raddr     = mma_pkg::elem_addr(t, j);
    mem.c_raddr     = mma_pkg::elem_addr(mma_pkg::CNT_W'(row), j);
    case (state)
      mma_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd)
            mma_pkg::CMD_LOAD_A: mem.a_we = (in_row < m_use) && (in_col < k_use);
            mma_pkg::CMD_LOAD_B: mem.b_we = (in_row < k_use) && (in_col < n_use);
            mma_pkg::CMD_LOAD_C: mem.c_we = (in_row < m_use) && (in_col < n_use);
            default: ;
          endcase
        end
      end
      mma_pkg::ST_COL: begin
        ctl.clr       = 1'b1;
        ctl.cold_load = 1'b1;
      end
      mma_pkg::ST_MAC: begin
        if (t < k_use) ctl.op = mma_pkg::OP_AB;
      end
      mma_pkg::ST_SCALE: begin
        case (s)
          2'd0:    ctl.op = mma_pkg::OP_ALPHA_LO;
          2'd1:    ctl.op = mma_pkg::OP_ALPHA_MID;
          2'd2:    ctl.op = mma_pkg::OP_ALPHA_HI;
          default: ctl.op = mma_pkg::OP_BETA;
        endcase
      end
      mma_pkg::ST_ROUND: begin
        // Write back the new element as it is emitted
        mem.c_we        = round_take;
        mem.c_wr_result = 1'b1;
        mem.wr_addr     = mma_pkg::elem_addr(mma_pkg::CNT_W'(row), j);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mma_pkg::ST_IDLE;
      t         <= '0;
      j         <= '0;
      s         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        mma_pkg::ST_IDLE: begin
          j <= '0;
        end
        mma_pkg::ST_COL: begin
          t <= '0;
          s <= '0;
        end
        mma_pkg::ST_MAC: begin
          if (t < k_use) t <= t + mma_pkg::CNT_W'(1);
        end
        mma_pkg::ST_SCALE: begin
          s <= s + 2'd1;
        end
        mma_pkg::ST_ROUND: begin
          if (round_take) j <= j + mma_pkg::CNT_W'(1);
        end
        default: ;
      endcase
      if (state == mma_pkg::ST_ROUND && round_take) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      row <= row_index;
    end
    if (state == mma_pkg::ST_ROUND && round_take) begin
      out_row   <= row;
      out_col   <= j[3:0];
      out_value <= stat.value;
      out_sat   <= stat.sat;
      out_last  <= last_col;
    end
  end

  `MMA_ASSERT_IMP(a_round_after_drain, clk, rst, state == mma_pkg::ST_ROUND, stat.idle)
  `MMA_ASSERT_IMP(a_idle_dp_quiet, clk, rst, state == mma_pkg::ST_IDLE, stat.idle)
  `MMA_ASSERT_NEXT(a_emit_with_writeback, clk, rst, mem.c_we && mem.c_wr_result, out_valid)

endmodule

// ===== tb/tb_matrix_multiply_accumulate_top.sv =====
`timescale 1ns / 1ps
module tb_matrix_multiply_accumulate_top;
  import mma_pkg::*;

  localparam int SETTLE_CYCLES = 500;
  localparam int HOLD_CYCLES   = 600;
  localparam int DIR_ROWS      = 24;
  localparam logic signed [127:0] SAT_HI   = 128'sd2147483647;
  localparam logic signed [127:0] SAT_LO   = -128'sd2147483648;
  localparam logic signed [127:0] HALF_LSB = 128'sd1 <<< (2 * FRAC_BITS - 1);

  typedef struct packed {
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] value;
    logic        sat;
    logic        last;
  } c_elem_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] value;
    logic        typed;
    logic [31:0] exp_value;
    logic        exp_sat;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // row_index[3:0], col_index[7:4], element_value[39:8]
  logic [1:0]  s_tuser;   // command[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // out_row[3:0], out_col[7:4], out_value[39:8]
  logic [0:0]  m_tuser;   // saturated[0]
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the block's registers and element stores
  logic [31:0]        cfg_alpha;
  logic [31:0]        cfg_beta;
  logic [4:0]         cfg_rows;
  logic [4:0]         cfg_inner;
  logic [4:0]         cfg_cols;
  logic signed [31:0] a_mem [DEPTH];
  logic signed [31:0] b_mem [DEPTH];
  logic signed [31:0] c_mem [DEPTH];
  bit                 a_wr [DEPTH];
  bit                 b_wr [DEPTH];
  bit                 c_wr [DEPTH];

  c_elem_t  c_elem_q[$];
  c_elem_t  want_elem;
  dir_row_t dir_tab [DIR_ROWS];
  int       mismatches;
  bit       idle_on;
  bit       hold_req;

  matrix_multiply_accumulate_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int in_use(logic [4:0] v);
    return (v > 5'd16) ? 16 : int'(v);
  endfunction

  function automatic logic [3:0] pick(int dim);
    return (dim > 0) ? 4'($urandom_range(0, dim - 1)) : 4'($urandom);
  endfunction

  function automatic logic [31:0] rand_elem();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: return r;
      1: return {{15{r[16]}}, r[16:0]};
      2: return {{8{r[23]}}, r[23:0]};
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0001_0000;
          4: return 32'hFFFF_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s at %0t: got %h want %h", field, $realtime, got, want);
    mismatches++;
  endtask

  // Apply one accepted request to the shadow stores and queue the C row it yields
  function automatic void predict_request(cmd_t cmd, logic [3:0] row, logic [3:0] col,
                                          logic [31:0] val);
    int m;
    int k;
    int n;
    int idx;
    logic signed [127:0] dot;
    logic signed [127:0] total;
    c_elem_t elem;
    m = in_use(cfg_rows);
    k = in_use(cfg_inner);
    n = in_use(cfg_cols);
    idx = row * MAX_DIM + col;
    case (cmd)
      CMD_LOAD_A: if (row < m && col < k) begin
        a_mem[idx] = val;
        a_wr[idx] = 1'b1;
      end
      CMD_LOAD_B: if (row < k && col < n) begin
        b_mem[idx] = val;
        b_wr[idx] = 1'b1;
      end
      CMD_LOAD_C: if (row < m && col < n) begin
        c_mem[idx] = val;
        c_wr[idx] = 1'b1;
      end
      default: if (row < m) begin
        for (int j = 0; j < n; j++) begin
          dot = '0;
          for (int t = 0; t < k; t++)
            dot = dot + a_mem[row * MAX_DIM + t] * b_mem[t * MAX_DIM + j];
          total = dot * $signed(cfg_alpha)
                + (($signed(cfg_beta) * c_mem[row * MAX_DIM + j]) <<< FRAC_BITS)
                + HALF_LSB;
          total = total >>> (2 * FRAC_BITS);
          elem.row = row;
          elem.col = 4'(j);
          elem.last = (j == n - 1);
          if (total > SAT_HI) begin
            elem.value = 32'h7FFF_FFFF;
            elem.sat = 1'b1;
          end else if (total < SAT_LO) begin
            elem.value = 32'h8000_0000;
            elem.sat = 1'b1;
          end else begin
            elem.value = total[31:0];
            elem.sat = 1'b0;
          end
          c_mem[row * MAX_DIM + j] = elem.value;
          c_wr[row * MAX_DIM + j] = 1'b1;
          c_elem_q = {c_elem_q, elem};
        end
      end
    endcase
  endfunction

  // Starts and ends at a falling edge; valid stays up for the next request
  task automatic send_request(cmd_t cmd, logic [3:0] row, logic [3:0] col,
                              logic [31:0] val);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = cmd;
    s_tdata = {val, col, row};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_request(cmd, row, col, val);
    @(negedge clk);
  endtask

  // Load any element that computing this row would read but was never written
  task automatic fill_operands(logic [3:0] row);
    int k;
    int n;
    k = in_use(cfg_inner);
    n = in_use(cfg_cols);
    for (int t = 0; t < k; t++)
      if (!a_wr[row * MAX_DIM + t]) send_request(CMD_LOAD_A, row, 4'(t), rand_elem());
    for (int t = 0; t < k; t++)
      for (int j = 0; j < n; j++)
        if (!b_wr[t * MAX_DIM + j]) send_request(CMD_LOAD_B, 4'(t), 4'(j), rand_elem());
    for (int j = 0; j < n; j++)
      if (!c_wr[row * MAX_DIM + j]) send_request(CMD_LOAD_C, row, 4'(j), rand_elem());
  endtask

  task automatic settle();
    s_tvalid = 1'b0;
    while (c_elem_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    logic [31:0] want;
    want = (idx == REG_ALPHA || idx == REG_BETA) ? val : 32'(val[4:0]);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_ALPHA:   cfg_alpha = val;
      REG_BETA:    cfg_beta = val;
      REG_ROWS_M:  cfg_rows = val[4:0];
      REG_INNER_K: cfg_inner = val[4:0];
      REG_COLS_N:  cfg_cols = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    if (prdata != want) report_mismatch("prdata", prdata, want);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_config(logic [31:0] alpha, logic [31:0] beta, logic [4:0] m,
                            logic [4:0] k, logic [4:0] n);
    settle();
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_BETA, beta);
    write_reg(REG_ROWS_M, 32'(m));
    write_reg(REG_INNER_K, 32'(k));
    write_reg(REG_COLS_N, 32'(n));
  endtask

  // Mostly well-formed loads and computes with random content, some noise
  task automatic run_random(int count);
    int m;
    int k;
    int n;
    cmd_t cmd;
    logic [3:0] row;
    logic [3:0] col;
    m = in_use(cfg_rows);
    k = in_use(cfg_inner);
    n = in_use(cfg_cols);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          row = pick(m);
          fill_operands(row);
          send_request(CMD_COMPUTE, row, 4'($urandom), $urandom);
        end
        3, 4, 5, 6, 7: begin
          cmd = cmd_t'($urandom_range(0, 2));
          case (cmd)
            CMD_LOAD_A: begin
              row = pick(m);
              col = pick(k);
            end
            CMD_LOAD_B: begin
              row = pick(k);
              col = pick(n);
            end
            default: begin
              row = pick(m);
              col = pick(n);
            end
          endcase
          send_request(cmd, row, col, rand_elem());
        end
        default: begin
          cmd = cmd_t'($urandom_range(0, 3));
          row = 4'($urandom);
          col = 4'($urandom);
          if (cmd == CMD_COMPUTE && row < m) fill_operands(row);
          send_request(cmd, row, col, $urandom);
        end
      endcase
    end
  endtask

  // Result consumer: random back-pressure plus one long hold-off on request
  initial begin
    int gap;
    gap = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready = 1'b0;
        gap = HOLD_CYCLES;
      end else if (gap > 0) begin
        m_tready = 1'b0;
        gap--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_tready = 1'b0;
        gap = $urandom_range(0, 3);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (c_elem_q.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[39:8], 32'h0);
      end else begin
        want_elem = c_elem_q.pop_front();
        if (m_tdata[3:0] != want_elem.row)
          report_mismatch("out_row", 32'(m_tdata[3:0]), 32'(want_elem.row));
        if (m_tdata[7:4] != want_elem.col)
          report_mismatch("out_col", 32'(m_tdata[7:4]), 32'(want_elem.col));
        if (m_tdata[39:8] != want_elem.value)
          report_mismatch("out_value", m_tdata[39:8], want_elem.value);
        if (m_tuser[0] != want_elem.sat)
          report_mismatch("saturated", 32'(m_tuser[0]), 32'(want_elem.sat));
        if (m_tlast != want_elem.last)
          report_mismatch("last", 32'(m_tlast), 32'(want_elem.last));
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    mismatches = 0;
    cfg_alpha = RESET_ALPHA;
    cfg_beta = '0;
    cfg_rows = RESET_DIM;
    cfg_inner = RESET_DIM;
    cfg_cols = RESET_DIM;
    for (int i = 0; i < DEPTH; i++) begin
      a_mem[i] = '0;
      b_mem[i] = '0;
      c_mem[i] = '0;
      a_wr[i] = 1'b0;
      b_wr[i] = 1'b0;
      c_wr[i] = 1'b0;
    end

    // One-term dot products, alpha 1.0, beta 0: results readable by hand
    dir_tab = '{
      '{CMD_LOAD_A,  4'd15, 4'd0,  32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
      '{CMD_LOAD_B,  4'd0,  4'd0,  32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
      '{CMD_LOAD_C,  4'd15, 4'd0,  32'h8000_0000, 1'b0, 32'h0,         1'b0},
      '{CMD_COMPUTE, 4'd15, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1},
      '{CMD_LOAD_A,  4'd15, 4'd15, 32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{CMD_LOAD_B,  4'd15, 4'd0,  32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{CMD_LOAD_C,  4'd0,  4'd15, 32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{CMD_LOAD_A,  4'd0,  4'd0,  32'h8000_0000, 1'b0, 32'h0,         1'b0},
      '{CMD_LOAD_C,  4'd0,  4'd0,  32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{CMD_COMPUTE, 4'd0,  4'd0,  32'h0000_0000, 1'b1, 32'h8000_0000, 1'b1},
      '{CMD_LOAD_B,  4'd0,  4'd0,  32'h0003_0000, 1'b0, 32'h0,         1'b0},
      '{CMD_LOAD_A,  4'd0,  4'd0,  32'h0001_0000, 1'b0, 32'h0,         1'b0},
      '{CMD_COMPUTE, 4'd0,  4'd7,  32'h5555_AAAA, 1'b1, 32'h0003_0000, 1'b0},
      '{CMD_LOAD_A,  4'd1,  4'd0,  32'hFFFF_0000, 1'b0, 32'h0,         1'b0},
      '{CMD_LOAD_C,  4'd1,  4'd0,  32'h1234_5678, 1'b0, 32'h0,         1'b0},
      '{CMD_COMPUTE, 4'd1,  4'd0,  32'h0000_0000, 1'b1, 32'hFFFD_0000, 1'b0},
      '{CMD_LOAD_B,  4'd0,  4'd0,  32'h0000_8000, 1'b0, 32'h0,         1'b0},
      '{CMD_LOAD_A,  4'd2,  4'd0,  32'h0000_0001, 1'b0, 32'h0,         1'b0},
      '{CMD_LOAD_C,  4'd2,  4'd0,  32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
      // exact half LSB: ties go up, to +1 and to 0
      '{CMD_COMPUTE, 4'd2,  4'd0,  32'h0000_0000, 1'b1, 32'h0000_0001, 1'b0},
      '{CMD_LOAD_A,  4'd3,  4'd0,  32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
      '{CMD_LOAD_C,  4'd3,  4'd0,  32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{CMD_COMPUTE, 4'd3,  4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_COMPUTE, 4'd1,  4'd15, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_8000, 1'b0}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_config(32'h0001_0000, 32'h0, 5'd16, 5'd1, 5'd1);
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_request(dir_tab[i].cmd, dir_tab[i].row, dir_tab[i].col, dir_tab[i].value);
      if (dir_tab[i].typed) begin
        c_elem_q[c_elem_q.size() - 1].value = dir_tab[i].exp_value;
        c_elem_q[c_elem_q.size() - 1].sat = dir_tab[i].exp_sat;
      end
    end

    set_config(rand_elem(), rand_elem(), 5'd4, 5'd3, 5'd4);
    run_random(6);
    set_config(32'h7FFF_FFFF, 32'h8000_0000, 5'd1, 5'd16, 5'd2);
    run_random(6);
    set_config(32'h8000_0000, 32'h7FFF_FFFF, 5'd1, 5'd1, 5'd16);
    // hold results back while requests keep coming, so the block backs up
    hold_req = 1'b1;
    fill_operands(4'd0);
    send_request(CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
    run_random(6);
    set_config($urandom, $urandom, 5'd1, 5'd1, 5'd1);
    run_random(6);
    // clamped row count, empty inner dimension
    set_config(32'h0001_0000, 32'h0000_8000, 5'd31, 5'd0, 5'd3);
    run_random(6);
    // no columns: computes emit nothing
    set_config(32'hFFFF_0000, 32'h0001_0000, 5'd5, 5'd4, 5'd0);
    run_random(6);

    idle_on = 1'b0;
    set_config(32'h0001_0000, 32'h0001_0000, 5'd3, 5'd3, 5'd3);
    run_random(10);

    settle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
